// ===== rtl/dcasm_pkg.sv =====
// dcasm_pkg: shared types and constants for the dual-channel averaging supply monitor
// no dependencies; imported by dcasm_lane, dcasm_merge and the top level
package dcasm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SAMPLE_MAX = 4095;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UV_WARN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UV_ERR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OC_WARN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OC_ERR  = 2'd3;

  // supply status codes
  localparam logic [STATUS_W-1:0] STAT_NONE    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_UV_WARN = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_UV_ERR  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_OC_WARN = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_OC_ERR  = 3'd4;

  // register reset values
  localparam logic [SAMPLE_W-1:0] UV_LEVEL_RST = 12'd0;
  localparam logic [SAMPLE_W-1:0] OC_LEVEL_RST = 12'd4095;

  // stage load strobes shared by both lanes
  typedef struct packed {
    logic ld_read;  // item enters read stage, ring read issued
    logic ld_sum;   // running sum updated, ring written
    logic ld_mul;   // mean multiply stage loads
    logic old_ok;   // ring entry under the read stage was written since reset
  } lane_ctl_t;

endpackage

// ===== rtl/dcasm_ram.sv =====
// dcasm_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
module dcasm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dcasm_lane.sv =====
// dcasm_lane: one channel of the boxcar average: sample ring, running sum, mean multiply
// depends on dcasm_pkg and dcasm_ram
module dcasm_lane
  import dcasm_pkg::*;
#(
  parameter int WINDOW_SIZE = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lane_ctl_t                      ctl,
  input  logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
  input  logic [$clog2(WINDOW_SIZE)-1:0] wr_addr,
  input  logic [SAMPLE_W-1:0]            sample,
  output logic [SAMPLE_W-1:0]            mean
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int SW = $clog2(WINDOW_SIZE * SAMPLE_MAX + 1);
  localparam int K  = SW + AW;
  localparam int MW = SW + 1;
  localparam int PW = SW + MW;
  // ceil(2^K / WINDOW_SIZE): exact quotient for any SW-bit sum
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << K) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
  localparam logic [MW-1:0] RECIP_M = RECIP_FULL[MW-1:0];

  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SW-1:0]       total_r;
  logic [SW-1:0]       total_nxt;
  logic [SW-1:0]       sum_r;
  logic [PW-1:0]       prod_r;

  dcasm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (ctl.ld_sum),
    .waddr (wr_addr),
    .wdata (sample_r),
    .re    (ctl.ld_read),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // entries not yet written since reset count as zero
  assign old_sample = ctl.old_ok ? rd_data : '0;
  assign total_nxt  = total_r - SW'(old_sample) + SW'(sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctl.ld_sum) begin
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_read) begin
      sample_r <= sample;
    end
    if (ctl.ld_sum) begin
      sum_r <= total_nxt;
    end
    if (ctl.ld_mul) begin
      prod_r <= PW'(sum_r) * PW'(RECIP_M);
    end
  end

  assign mean = prod_r[K +: SAMPLE_W];

endmodule

// ===== rtl/dcasm_merge.sv =====
// dcasm_merge: threshold registers, status priority and the result register
// depends on dcasm_pkg
module dcasm_merge
  import dcasm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [SAMPLE_W-1:0]  cfg_wdata,
  input  logic                 ld_out,
  input  logic [SAMPLE_W-1:0]  mean_cur,
  input  logic [SAMPLE_W-1:0]  mean_vol,
  output logic [SAMPLE_W-1:0]  res_mean_cur,
  output logic [SAMPLE_W-1:0]  res_mean_vol,
  output logic [STATUS_W-1:0]  res_status
);

  logic [SAMPLE_W-1:0] uv_warn_r;
  logic [SAMPLE_W-1:0] uv_err_r;
  logic [SAMPLE_W-1:0] oc_warn_r;
  logic [SAMPLE_W-1:0] oc_err_r;
  logic [SAMPLE_W-1:0] mean_cur_r;
  logic [SAMPLE_W-1:0] mean_vol_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_warn_r <= UV_LEVEL_RST;
      uv_err_r  <= UV_LEVEL_RST;
      oc_warn_r <= OC_LEVEL_RST;
      oc_err_r  <= OC_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_UV_WARN: uv_warn_r <= cfg_wdata;
        CFG_UV_ERR:  uv_err_r  <= cfg_wdata;
        CFG_OC_WARN: oc_warn_r <= cfg_wdata;
        CFG_OC_ERR:  oc_err_r  <= cfg_wdata;
        default:     uv_warn_r <= uv_warn_r;
      endcase
    end
  end

  // earlier checks take priority over later ones, so test from the highest code down
  always_comb begin
    if (mean_cur > oc_err_r) begin
      status_nxt = STAT_OC_ERR;
    end else if (mean_cur > oc_warn_r) begin
      status_nxt = STAT_OC_WARN;
    end else if (mean_vol < uv_err_r) begin
      status_nxt = STAT_UV_ERR;
    end else if (mean_vol < uv_warn_r) begin
      status_nxt = STAT_UV_WARN;
    end else begin
      status_nxt = STAT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      mean_cur_r <= mean_cur;
      mean_vol_r <= mean_vol;
      status_r   <= status_nxt;
    end
  end

  assign res_mean_cur = mean_cur_r;
  assign res_mean_vol = mean_vol_r;
  assign res_status   = status_r;

endmodule

// ===== rtl/dual_channel_average_supply_monitor_unit.sv =====
// dual_channel_average_supply_monitor_unit: top level of the two-channel boxcar monitor
// depends on dcasm_pkg, dcasm_lane (with dcasm_ram) and dcasm_merge
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_stall    | current_sample, voltage_sample
//   out_    | output    | out_valid / out_stall  | mean_current, mean_voltage, supply_status
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; out_valid rises when an item clears
// ring read, sum update and ring write, mean multiply, compare into the result register
// each stage holds an item on its own, so items keep entering while a result waits
// reset clears the running sums, ring position and fill flag; no clearing pass is needed
// cfg_ready is always high
module dual_channel_average_supply_monitor_unit
  import dcasm_pkg::*;
#(
  parameter int WINDOW_SIZE = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_current_sample,
  input  logic [SAMPLE_W-1:0]  in_voltage_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SAMPLE_W-1:0]  out_mean_current,
  output logic [SAMPLE_W-1:0]  out_mean_voltage,
  output logic [STATUS_W-1:0]  out_supply_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] POS_LAST = AW'(WINDOW_SIZE - 1);

  logic          v1_r, v2_r, v3_r, out_valid_r;
  logic          rdy1, rdy2, rdy3, rdy4;
  logic          ld1, ld2, ld3, ld4;
  logic [AW-1:0] pos_r;
  logic [AW-1:0] pos_nxt;
  logic [AW-1:0] wpos_r;
  logic          filled_r;
  logic          fill1_r;
  lane_ctl_t     ctl;
  logic [SAMPLE_W-1:0] mean_cur;
  logic [SAMPLE_W-1:0] mean_vol;

  // per-stage ready: a stage takes an item when empty or when its item moves on
  assign rdy4 = !out_valid_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall = !rdy1;
  assign ld1 = in_valid && rdy1;
  assign ld2 = v1_r && rdy2;
  assign ld3 = v2_r && rdy3;
  assign ld4 = v3_r && rdy4;

  assign pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      filled_r    <= 1'b0;
      fill1_r     <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
      if (ld1) begin
        pos_r   <= pos_nxt;
        fill1_r <= filled_r;
        if (pos_r == POS_LAST) filled_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      wpos_r <= pos_r;
    end
  end

  assign ctl.ld_read = ld1;
  assign ctl.ld_sum  = ld2;
  assign ctl.ld_mul  = ld3;
  assign ctl.old_ok  = fill1_r;

  dcasm_lane #(.WINDOW_SIZE(WINDOW_SIZE)) u_lane_cur (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (pos_r),
    .wr_addr (wpos_r),
    .sample  (in_current_sample),
    .mean    (mean_cur)
  );

  dcasm_lane #(.WINDOW_SIZE(WINDOW_SIZE)) u_lane_vol (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (pos_r),
    .wr_addr (wpos_r),
    .sample  (in_voltage_sample),
    .mean    (mean_vol)
  );

  dcasm_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_idx      (cfg_index),
    .cfg_wdata    (cfg_data),
    .ld_out       (ld4),
    .mean_cur     (mean_cur),
    .mean_vol     (mean_vol),
    .res_mean_cur (out_mean_current),
    .res_mean_vol (out_mean_voltage),
    .res_status   (out_supply_status)
  );

  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted item not held in read stage");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("ring position beyond window");

  a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r |=> filled_r)
    else $error("fill flag dropped after first wrap");

endmodule
